/* sv/ccb_pkg.sv */
package ccb_pkg;

    // Character codes used by the lexer
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SP    = 8'h20;

    // Result queue geometry
    localparam int unsigned RQ_DEPTH = 4;
    localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);
    localparam int unsigned RQ_CW    = $clog2(RQ_DEPTH + 1);

    // One result transfer
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       text_end;
    } result_t;

endpackage

/* sv/c_comment_blanker_core.sv */
// Channel   Ports                                   Direction  Carries
// s_        s_valid s_ready s_in_byte s_in_final    in         source byte, last-byte mark
// m_        m_valid m_ready m_out_byte m_run_end    out        blanked byte, end of item,
//           m_text_end                                         end of text
//
// An input byte is lexed in the cycle it is accepted and its 0, 1 or 2 results are
// written into a 4-entry result queue; the first result is visible the next cycle.
// Sustained rate is one byte per cycle while each byte yields at most one result and
// m_ready is high; a two-result byte adds an output transfer, absorbed by the queue.
// s_ready is high while the queue has room for two results (at most 2 entries held).
// Synchronous active-low reset returns the lexer to code mode and empties the queue.
// A final byte returns the lexer to its reset state for the next text.
module c_comment_blanker_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_final,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_end,
    output logic       m_text_end
);

    typedef enum logic [2:0] {
        MODE_CODE   = 3'd0,
        MODE_LINE   = 3'd1,
        MODE_BLOCK  = 3'd2,
        MODE_STRING = 3'd3,
        MODE_CHAR   = 3'd4
    } lex_mode_t;

    lex_mode_t mode_reg, mode_next;
    logic      held_reg, held_next;
    logic      esc_reg, esc_next;

    logic [ccb_pkg::RQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ccb_pkg::RQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ccb_pkg::RQ_CW-1:0] count_reg, count_next;
    ccb_pkg::result_t          rq_mem [ccb_pkg::RQ_DEPTH];

    logic       s_xfer, m_xfer;
    logic       pre_v, main_v;
    logic [7:0] pre_b, main_b;
    logic [7:0] closer;
    logic [1:0] n_res;
    logic [1:0] push_n;
    ccb_pkg::result_t res0, res1;

    assign s_xfer  = s_valid && s_ready;
    assign m_xfer  = m_valid && m_ready;
    assign s_ready = (count_reg <= ccb_pkg::RQ_CW'(ccb_pkg::RQ_DEPTH - 2));
    assign m_valid = (count_reg != '0);

    // Lex one byte: optional leading result, optional main result, next state
    always_comb begin
        pre_v     = 1'b0;
        pre_b     = ccb_pkg::CH_SP;
        main_v    = 1'b0;
        main_b    = s_in_byte;
        mode_next = mode_reg;
        held_next = held_reg;
        esc_next  = esc_reg;
        closer    = (mode_reg == MODE_CHAR) ? ccb_pkg::CH_SQ : ccb_pkg::CH_DQ;
        unique case (mode_reg)
            MODE_LINE: begin
                main_v = 1'b1;
                if (s_in_byte == ccb_pkg::CH_NL) begin
                    mode_next = MODE_CODE;
                    main_b    = ccb_pkg::CH_NL;
                end else begin
                    main_b = ccb_pkg::CH_SP;
                end
            end
            MODE_BLOCK: begin
                if (held_reg) begin
                    held_next = 1'b0;
                    pre_v     = 1'b1;
                end
                if (held_reg && s_in_byte == ccb_pkg::CH_SLASH) begin
                    // close the comment: both delimiter bytes blank
                    mode_next = MODE_CODE;
                    main_v    = 1'b1;
                    main_b    = ccb_pkg::CH_SP;
                end else if (s_in_byte == ccb_pkg::CH_STAR && !s_in_final) begin
                    held_next = 1'b1;
                end else if (s_in_byte == ccb_pkg::CH_NL) begin
                    main_v = 1'b1;
                    main_b = ccb_pkg::CH_NL;
                end else begin
                    main_v = 1'b1;
                    main_b = ccb_pkg::CH_SP;
                end
            end
            MODE_STRING, MODE_CHAR: begin
                main_v = 1'b1;
                if (!esc_reg && s_in_byte == closer) begin
                    mode_next = MODE_CODE;
                end
                esc_next = !esc_reg && (s_in_byte == ccb_pkg::CH_BSL);
            end
            default: begin
                mode_next = MODE_CODE;
                if (held_reg) begin
                    held_next = 1'b0;
                    pre_v     = 1'b1;
                end
                if (held_reg && s_in_byte == ccb_pkg::CH_SLASH) begin
                    mode_next = MODE_LINE;
                    main_v    = 1'b1;
                    main_b    = ccb_pkg::CH_SP;
                end else if (held_reg && s_in_byte == ccb_pkg::CH_STAR) begin
                    mode_next = MODE_BLOCK;
                    main_v    = 1'b1;
                    main_b    = ccb_pkg::CH_SP;
                end else begin
                    // flush a held slash as itself, then lex the byte as code
                    pre_b = ccb_pkg::CH_SLASH;
                    if (s_in_byte == ccb_pkg::CH_DQ) begin
                        mode_next = MODE_STRING;
                        main_v    = 1'b1;
                    end else if (s_in_byte == ccb_pkg::CH_SQ) begin
                        mode_next = MODE_CHAR;
                        main_v    = 1'b1;
                    end else if (s_in_byte == ccb_pkg::CH_SLASH && !s_in_final) begin
                        held_next = 1'b1;
                    end else begin
                        main_v = 1'b1;
                    end
                end
            end
        endcase
        // end of text: start the next one from reset state
        if (s_in_final) begin
            mode_next = MODE_CODE;
            held_next = 1'b0;
            esc_next  = 1'b0;
        end
    end

    // Pack results for the queue
    always_comb begin
        n_res          = {1'b0, pre_v} + {1'b0, main_v};
        res0.out_byte  = pre_v ? pre_b : main_b;
        res0.run_end   = (n_res == 2'd1);
        res0.text_end  = (n_res == 2'd1) && s_in_final;
        res1.out_byte  = main_b;
        res1.run_end   = 1'b1;
        res1.text_end  = s_in_final;
        push_n         = s_xfer ? n_res : 2'd0;
        wr_ptr_next    = wr_ptr_reg + ccb_pkg::RQ_AW'(push_n);
        rd_ptr_next    = rd_ptr_reg + ccb_pkg::RQ_AW'(m_xfer);
        count_next     = count_reg + ccb_pkg::RQ_CW'(push_n) - ccb_pkg::RQ_CW'(m_xfer);
    end

    // Hold lexer state and queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_CODE;
            held_reg   <= 1'b0;
            esc_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (s_xfer) begin
                mode_reg <= mode_next;
                held_reg <= held_next;
                esc_reg  <= esc_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write results into the queue
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            rq_mem[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2) begin
            rq_mem[ccb_pkg::RQ_AW'(wr_ptr_reg + 1'b1)] <= res1;
        end
    end

    // Drive the result channel from the queue head
    assign m_out_byte = rq_mem[rd_ptr_reg].out_byte;
    assign m_run_end  = rq_mem[rd_ptr_reg].run_end;
    assign m_text_end = rq_mem[rd_ptr_reg].text_end;

    // Queue never overflows
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ccb_pkg::RQ_CW'(ccb_pkg::RQ_DEPTH))
        else $error("result queue overflow");

    // Pointers stay consistent with the fill count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg - rd_ptr_reg) == ccb_pkg::RQ_AW'(count_reg))
        else $error("result queue pointers disagree with count");

    // A held delimiter exists only in code or block comment mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg |-> (mode_reg == MODE_CODE || mode_reg == MODE_BLOCK))
        else $error("delimiter held outside code or block comment");

    // An escape is pending only inside a literal
    assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> (mode_reg == MODE_STRING || mode_reg == MODE_CHAR))
        else $error("escape pending outside a literal");

    // A final byte leaves the lexer in its reset state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_in_final) |=> (mode_reg == MODE_CODE && !held_reg && !esc_reg))
        else $error("lexer state not cleared after final byte");

endmodule

/* verif/tb_c_comment_blanker_core.sv */
`timescale 1ns / 1ps

module tb_c_comment_blanker_core;

    // Lexer modes of the blanking predictor
    typedef enum logic [2:0] {
        LX_CODE   = 3'd0,
        LX_LINE   = 3'd1,
        LX_BLOCK  = 3'd2,
        LX_STRING = 3'd3,
        LX_CHAR   = 3'd4
    } lex_mode_t;

    // One source byte plus, for hand-checked rows, the results typed in
    typedef struct packed {
        logic [7:0]       ch;
        logic             fin;
        logic             typed;
        logic [1:0]       n;
        ccb_pkg::result_t r0;
        ccb_pkg::result_t r1;
    } src_item_t;

    localparam ccb_pkg::result_t NO_RES = '0;
    localparam int               N_DIR  = 28;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte  = 8'h00;
    logic       s_in_final = 1'b0;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_run_end;
    logic       m_text_end;

    src_item_t        src_q [$];
    ccb_pkg::result_t blanked_q [$];
    src_item_t        dir_tab [0:N_DIR-1];
    src_item_t        drv_item;

    int src_idle = 0;
    int dst_idle = 0;
    int fail_cnt = 0;

    // Predictor state
    lex_mode_t  lex_q  = LX_CODE;
    logic       esc_q  = 1'b0;
    logic       held_q = 1'b0;
    logic [7:0] stage_b [2];
    int         stage_n;

    c_comment_blanker_core i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_final (s_in_final),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_end  (m_run_end),
        .m_text_end (m_text_end)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Blanking predictor
    // ------------------------------------------------------------------
    function automatic void stage(input logic [7:0] b);
        if (stage_n < 2) begin
            stage_b[stage_n] = b;
            stage_n++;
        end
    endfunction

    // Code byte with nothing held: open a literal, hold a slash, or pass
    function automatic void code_in(input logic [7:0] c, input logic fin);
        if (c == ccb_pkg::CH_DQ) begin
            lex_q = LX_STRING;
            stage(c);
        end else if (c == ccb_pkg::CH_SQ) begin
            lex_q = LX_CHAR;
            stage(c);
        end else if (c == ccb_pkg::CH_SLASH && !fin) begin
            held_q = 1'b1;
        end else begin
            stage(c);
        end
    endfunction

    // Block comment byte with nothing held: hold a star, keep newlines, blank the rest
    function automatic void block_in(input logic [7:0] c, input logic fin);
        if (c == ccb_pkg::CH_STAR && !fin) begin
            held_q = 1'b1;
        end else if (c == ccb_pkg::CH_NL) begin
            stage(ccb_pkg::CH_NL);
        end else begin
            stage(ccb_pkg::CH_SP);
        end
    endfunction

    // Literal byte: pass through, close on an unescaped closer, track backslashes
    function automatic void lit_in(input logic [7:0] c, input logic [7:0] closer);
        stage(c);
        if (!esc_q && c == closer) begin
            lex_q = LX_CODE;
        end
        esc_q = !esc_q && c == ccb_pkg::CH_BSL;
    endfunction

    function automatic void blank_byte(input logic [7:0] c, input logic fin);
        stage_n = 0;
        case (lex_q)
            LX_LINE: begin
                if (c == ccb_pkg::CH_NL) begin
                    lex_q = LX_CODE;
                    stage(ccb_pkg::CH_NL);
                end else begin
                    stage(ccb_pkg::CH_SP);
                end
            end
            LX_BLOCK: begin
                if (held_q) begin
                    held_q = 1'b0;
                    if (c == ccb_pkg::CH_SLASH) begin
                        lex_q = LX_CODE;
                        stage(ccb_pkg::CH_SP);
                        stage(ccb_pkg::CH_SP);
                    end else begin
                        stage(ccb_pkg::CH_SP);
                        block_in(c, fin);
                    end
                end else begin
                    block_in(c, fin);
                end
            end
            LX_STRING: lit_in(c, ccb_pkg::CH_DQ);
            LX_CHAR:   lit_in(c, ccb_pkg::CH_SQ);
            default: begin
                lex_q = LX_CODE;
                if (held_q) begin
                    held_q = 1'b0;
                    if (c == ccb_pkg::CH_SLASH) begin
                        lex_q = LX_LINE;
                        stage(ccb_pkg::CH_SP);
                        stage(ccb_pkg::CH_SP);
                    end else if (c == ccb_pkg::CH_STAR) begin
                        lex_q = LX_BLOCK;
                        stage(ccb_pkg::CH_SP);
                        stage(ccb_pkg::CH_SP);
                    end else begin
                        stage(ccb_pkg::CH_SLASH);
                        code_in(c, fin);
                    end
                end else begin
                    code_in(c, fin);
                end
            end
        endcase
        // A final byte starts the next text from scratch
        if (fin) begin
            lex_q  = LX_CODE;
            esc_q  = 1'b0;
            held_q = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Random source text
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 14)      return ccb_pkg::CH_SLASH;
        else if (r < 26) return ccb_pkg::CH_STAR;
        else if (r < 33) return ccb_pkg::CH_DQ;
        else if (r < 39) return ccb_pkg::CH_SQ;
        else if (r < 46) return ccb_pkg::CH_BSL;
        else if (r < 54) return ccb_pkg::CH_NL;
        else if (r < 61) return ccb_pkg::CH_SP;
        else if (r < 85) return 8'h61 + 8'($urandom_range(0, 25));
        else             return 8'($urandom_range(0, 255));
    endfunction

    // Build one text from comment, literal and code fragments; mark its last byte
    task automatic add_text(output int len);
        logic [7:0] txt [$];
        int         nfrag;
        src_item_t  it;
        nfrag = $urandom_range(1, 6);
        repeat (nfrag) begin
            case ($urandom_range(0, 9))
                0, 1: repeat ($urandom_range(1, 6)) txt = {txt, 8'h61 + 8'($urandom_range(0, 25))};
                2: begin
                    txt = {txt, ccb_pkg::CH_SLASH};
                    txt = {txt, ccb_pkg::CH_SLASH};
                    repeat ($urandom_range(0, 8)) txt = {txt, pick_char()};
                    if ($urandom_range(0, 9) != 0) txt = {txt, ccb_pkg::CH_NL};
                end
                3: begin
                    txt = {txt, ccb_pkg::CH_SLASH};
                    txt = {txt, ccb_pkg::CH_STAR};
                    repeat ($urandom_range(0, 8)) txt = {txt, pick_char()};
                    if ($urandom_range(0, 9) != 0) begin
                        txt = {txt, ccb_pkg::CH_STAR};
                        txt = {txt, ccb_pkg::CH_SLASH};
                    end
                end
                4: begin
                    txt = {txt, ccb_pkg::CH_DQ};
                    repeat ($urandom_range(0, 8)) txt = {txt, pick_char()};
                    txt = {txt, ccb_pkg::CH_DQ};
                end
                5: begin
                    txt = {txt, ccb_pkg::CH_SQ};
                    repeat ($urandom_range(1, 2)) txt = {txt, pick_char()};
                    txt = {txt, ccb_pkg::CH_SQ};
                end
                6: begin
                    txt = {txt, $urandom_range(0, 1) ? ccb_pkg::CH_SLASH : ccb_pkg::CH_STAR};
                    txt = {txt, 8'h61 + 8'($urandom_range(0, 25))};
                end
                7, 8: txt = {txt, pick_char()};
                default: repeat ($urandom_range(1, 4)) txt = {txt, 8'($urandom_range(0, 255))};
            endcase
        end
        foreach (txt[j]) begin
            it     = '0;
            it.ch  = txt[j];
            it.fin = (j == txt.size() - 1);
            src_q  = {src_q, it};
        end
        len = txt.size();
    endtask

    // ------------------------------------------------------------------
    // Source side: predict on each transfer, then offer the next byte
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_src
        ccb_pkg::result_t nr;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                blank_byte(s_in_byte, s_in_final);
                if (drv_item.typed) begin
                    if (drv_item.n >= 2'd1) blanked_q = {blanked_q, drv_item.r0};
                    if (drv_item.n == 2'd2) blanked_q = {blanked_q, drv_item.r1};
                end else begin
                    for (int k = 0; k < stage_n; k++) begin
                        nr.out_byte = stage_b[k];
                        nr.run_end  = (k == stage_n - 1);
                        nr.text_end = (k == stage_n - 1) && s_in_final;
                        blanked_q   = {blanked_q, nr};
                    end
                end
            end
            if (!s_valid || s_ready) begin
                if (src_q.size() != 0 && $urandom_range(0, 99) >= src_idle) begin
                    drv_item = src_q.pop_front();
                    s_valid    <= 1'b1;
                    s_in_byte  <= drv_item.ch;
                    s_in_final <= drv_item.fin;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: compare each transfer with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_dst
        ccb_pkg::result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (blanked_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected result out_byte %02h run_end %0b text_end %0b",
                             $time, m_out_byte, m_run_end, m_text_end);
                end else begin
                    want = blanked_q.pop_front();
                    if (m_out_byte !== want.out_byte) begin
                        fail_cnt++;
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want.out_byte, m_out_byte);
                    end
                    if (m_run_end !== want.run_end) begin
                        fail_cnt++;
                        $display("%0t: run_end expected %0b actual %0b",
                                 $time, want.run_end, m_run_end);
                    end
                    if (m_text_end !== want.text_end) begin
                        fail_cnt++;
                        $display("%0t: text_end expected %0b actual %0b",
                                 $time, want.text_end, m_text_end);
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= dst_idle);
        end
    end

    // ------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------
    initial begin : run_seq
        int len;
        int phase_cnt;
        dir_tab = '{
            // zero byte in code
            '{8'h00, 1'b0, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b0}, NO_RES},
            // top byte in code
            '{8'hFF, 1'b0, 1'b1, 2'd1, '{8'hFF, 1'b1, 1'b0}, NO_RES},
            // slash held
            '{ccb_pkg::CH_SLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
            // held slash flushed
            '{8'h78, 1'b0, 1'b1, 2'd2, '{ccb_pkg::CH_SLASH, 1'b0, 1'b0},
                                       '{8'h78, 1'b1, 1'b0}},
            '{ccb_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ccb_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},  // line comment opens
            '{8'hFF,             1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ccb_pkg::CH_NL,    1'b0, 1'b0, 2'd0, NO_RES, NO_RES},  // line comment closes
            '{ccb_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ccb_pkg::CH_STAR,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},  // block comment opens
            '{ccb_pkg::CH_STAR,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ccb_pkg::CH_STAR,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},  // star held again
            '{ccb_pkg::CH_NL,    1'b0, 1'b0, 2'd0, NO_RES, NO_RES},  // held star, newline kept
            '{ccb_pkg::CH_STAR,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ccb_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},  // block comment closes
            '{ccb_pkg::CH_DQ,    1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ccb_pkg::CH_BSL,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ccb_pkg::CH_DQ,    1'b0, 1'b0, 2'd0, NO_RES, NO_RES},  // escaped quote
            '{ccb_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},  // slash inside string
            '{ccb_pkg::CH_DQ,    1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ccb_pkg::CH_SQ,    1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ccb_pkg::CH_BSL,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ccb_pkg::CH_SQ,    1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ccb_pkg::CH_SQ,    1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            // final slash
            '{ccb_pkg::CH_SLASH, 1'b1, 1'b1, 2'd1, '{ccb_pkg::CH_SLASH, 1'b1, 1'b1}, NO_RES},
            '{ccb_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ccb_pkg::CH_STAR,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ccb_pkg::CH_STAR,  1'b1, 1'b0, 2'd0, NO_RES, NO_RES}   // final star in comment
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < 3; ph++) begin
            @(negedge aclk);
            case (ph)
                0:       begin src_idle = 26; dst_idle = 85; end
                1:       begin src_idle = 85; dst_idle = 26; end
                default: begin src_idle = 0;  dst_idle = 0;  end
            endcase
            // Directed rows lead the first phase
            if (ph == 0) begin
                for (int i = 0; i < N_DIR; i++) src_q = {src_q, dir_tab[i]};
            end
            phase_cnt = 0;
            while (phase_cnt < 370) begin
                add_text(len);
                phase_cnt += len;
            end
            while (src_q.size() != 0 || s_valid) @(posedge aclk);
        end

        // Drain outstanding results, then watch for strays
        while (blanked_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (fail_cnt == 0 && blanked_q.size() == 0) begin
            $display("tb_c_comment_blanker_core: PASS");
        end else begin
            $display("tb_c_comment_blanker_core: FAIL");
        end
        $finish;
    end

    // Hard stop on a hung handshake
    initial begin
        #5_000_000;
        $display("tb_c_comment_blanker_core: FAIL");
        $finish;
    end

endmodule
